@@ sv/v34te_pkg.sv @@
// ----------------------------------------------------------------------------
// V.34 4D trellis encoder package
// Shared constants, the trellis kind codes and the subset and pair tables.
// ----------------------------------------------------------------------------
package v34te_pkg;

    // Default coordinate width of one point component.
    localparam int COORD_BITS_DEF = 9;

    // Width of the trellis state register.
    localparam int STATE_BITS = 6;

    // Trellis code selected by the configuration register.
    typedef enum logic [1:0] {
        KIND_16 = 2'd0,
        KIND_32 = 2'd1,
        KIND_64 = 2'd2
    } kind_t;

    typedef logic [2:0] label_t;
    typedef logic [3:0] ybits_t;

    // 2D subset label, indexed by row then column of the quarter-plane cell.
    localparam label_t LABEL_MAP [4][4] = '{
        '{3'd1, 3'd6, 3'd5, 3'd2},
        '{3'd4, 3'd3, 3'd0, 3'd7},
        '{3'd5, 3'd2, 3'd1, 3'd6},
        '{3'd0, 3'd7, 3'd4, 3'd3}
    };

    // Bits y4..y1 for a label pair; columns 4..7 are columns 0..3 with y4 inverted.
    localparam ybits_t PAIR_MAP [4][8] = '{
        '{4'h0, 4'h0, 4'h1, 4'h1, 4'h8, 4'h8, 4'h9, 4'h9},
        '{4'h3, 4'h2, 4'h2, 4'h3, 4'hb, 4'ha, 4'ha, 4'hb},
        '{4'h5, 4'h5, 4'h4, 4'h4, 4'hd, 4'hd, 4'hc, 4'hc},
        '{4'h6, 4'h7, 4'h7, 4'h6, 4'he, 4'hf, 4'hf, 4'he}
    };

    // Subset label of a point from the low three bits of its coordinates.
    function automatic label_t subset_label(input logic [2:0] re_lo,
                                            input logic [2:0] im_lo);
        logic [2:0] col_sum;
        logic [2:0] row_dif;
        col_sum = re_lo + 3'd3;
        row_dif = 3'd3 - im_lo;
        return LABEL_MAP[row_dif[2:1]][col_sum[2:1]];
    endfunction

    // Pair lookup giving y4..y1.
    function automatic ybits_t pair_bits(input label_t l1, input label_t l2);
        return PAIR_MAP[l1[1:0]][l2] ^ {l1[2], 3'b000};
    endfunction

endpackage

@@ sv/v34_four_d_trellis_encoder_top.sv @@
// ----------------------------------------------------------------------------
// V.34 4D trellis encoder, top level
// Stream wrapper with input register, datapath, state and result register.
// ----------------------------------------------------------------------------
// Usage:
// One 4D symbol is taken per transfer on the s_ channel and one result leaves
// per transfer on the m_ channel, in the same order. An accepted symbol is
// written to the input register, then passes the datapath into the result
// register, which drives m_tvalid. While the receiver does not stall, a new
// symbol can be taken every cycle: the sustained rate is one symbol per
// clock, set by the single datapath pass between the input and result
// registers, which also updates the trellis state.
// When the receiver stalls, the result register holds its data and the input
// register still takes one more symbol; s_tready drops only when both hold
// data. The user writes the trellis kind over cfg_wr_en / cfg_wr_data only
// while the block is idle; the block does not enforce this. A write of a
// valid kind also clears the trellis state, the unused code is ignored. Reset
// (rst_n low) empties both registers and sets the 16-state code, state cleared.
// ----------------------------------------------------------------------------
module v34_four_d_trellis_encoder_top #(
    parameter int COORD_BITS = v34te_pkg::COORD_BITS_DEF,
    localparam int IN_W   = 4 * COORD_BITS + 4,
    localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 4 * COORD_BITS + 2,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration: trellis kind.
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    // Input symbols.
    input  logic               s_tvalid,
    output logic               s_tready,
    // From bit 0: first_re, first_im, second_re, second_im, rotation,
    // extra_turn_bit, differential_bit, zero fill.
    input  logic [IN_TW-1:0]   s_tdata,
    // Results.
    output logic               m_tvalid,
    input  logic               m_tready,
    // From bit 0: out_first_re, out_first_im, out_second_re, out_second_im,
    // coded_bit, valid_points, zero fill.
    output logic [OUT_TW-1:0]  m_tdata
);

    localparam int CB = COORD_BITS;

    logic                                   in_valid_reg;
    logic [IN_W-1:0]                        in_data_reg;
    logic                                   out_valid_reg;
    logic [OUT_W-1:0]                       out_data_reg;
    logic [v34te_pkg::STATE_BITS-1:0]       state_reg;
    logic [v34te_pkg::STATE_BITS-1:0]       state_next;
    v34te_pkg::kind_t                       kind_reg;

    logic                                   out_free;
    logic                                   advance;
    logic                                   in_take;
    logic [OUT_W-1:0]                       result;

    // Handshake: the result register frees when empty or when its transfer
    // completes; the input register moves on whenever the result side is free.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    // Datapath between the input and result registers.
    v34te_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .first_re         (in_data_reg[CB-1:0]),
        .first_im         (in_data_reg[2*CB-1:CB]),
        .second_re        (in_data_reg[3*CB-1:2*CB]),
        .second_im        (in_data_reg[4*CB-1:3*CB]),
        .rotation         (in_data_reg[4*CB+1:4*CB]),
        .extra_turn_bit   (in_data_reg[4*CB+2]),
        .differential_bit (in_data_reg[4*CB+3]),
        .kind             (kind_reg),
        .state            (state_reg),
        .out_first_re     (result[CB-1:0]),
        .out_first_im     (result[2*CB-1:CB]),
        .out_second_re    (result[3*CB-1:2*CB]),
        .out_second_im    (result[4*CB-1:3*CB]),
        .coded_bit        (result[4*CB]),
        .valid_points     (result[4*CB+1]),
        .state_next       (state_next)
    );

    // Control registers: stage valids, trellis kind and state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= v34te_pkg::KIND_16;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // The user writes configuration only while idle; the block does not enforce it.
            if (cfg_wr_en && (cfg_wr_data <= v34te_pkg::KIND_64))
            begin
                kind_reg  <= v34te_pkg::kind_t'(cfg_wr_data);
                state_reg <= '0;
            end
            else if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_tdata[IN_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TW - OUT_W){1'b0}}, out_data_reg};

endmodule

@@ sv/v34te_core.sv @@
// ----------------------------------------------------------------------------
// V.34 4D trellis encoder datapath
// Rotates both points, labels them and computes the next trellis state.
// ----------------------------------------------------------------------------
module v34te_core #(
    parameter int COORD_BITS = v34te_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]            first_re,
    input  logic signed [COORD_BITS-1:0]            first_im,
    input  logic signed [COORD_BITS-1:0]            second_re,
    input  logic signed [COORD_BITS-1:0]            second_im,
    input  logic [1:0]                              rotation,
    input  logic                                    extra_turn_bit,
    input  logic                                    differential_bit,
    input  v34te_pkg::kind_t                        kind,
    input  logic [v34te_pkg::STATE_BITS-1:0]        state,
    output logic signed [COORD_BITS-1:0]            out_first_re,
    output logic signed [COORD_BITS-1:0]            out_first_im,
    output logic signed [COORD_BITS-1:0]            out_second_re,
    output logic signed [COORD_BITS-1:0]            out_second_im,
    output logic                                    coded_bit,
    output logic                                    valid_points,
    output logic [v34te_pkg::STATE_BITS-1:0]        state_next
);

    logic [1:0]                 turns_second;
    logic                       u0;
    v34te_pkg::label_t          label_first;
    v34te_pkg::label_t          label_second;
    v34te_pkg::ybits_t          ybits;
    logic                       y1, y2, y3, y4;
    logic                       d0, d1, d2, d3, d4;
    logic                       mix_a, mix_b;

    // Trellis output bit before this step.
    always_comb
    begin
        unique case (kind)
            v34te_pkg::KIND_16: coded_bit = state[3];
            v34te_pkg::KIND_32: coded_bit = state[4];
            v34te_pkg::KIND_64: coded_bit = state[5];
            default:            coded_bit = 1'b0;
        endcase
    end

    assign u0           = coded_bit ^ differential_bit;
    assign turns_second = rotation + {extra_turn_bit, 1'b0} + {1'b0, u0};

    // Clockwise quarter turns of the first point: (re, im) -> (im, -re).
    always_comb
    begin
        case (rotation)
            2'd1:
            begin
                out_first_re = first_im;
                out_first_im = -first_re;
            end
            2'd2:
            begin
                out_first_re = -first_re;
                out_first_im = -first_im;
            end
            2'd3:
            begin
                out_first_re = -first_im;
                out_first_im = first_re;
            end
            default:
            begin
                out_first_re = first_re;
                out_first_im = first_im;
            end
        endcase
    end

    // Clockwise quarter turns of the second point.
    always_comb
    begin
        case (turns_second)
            2'd1:
            begin
                out_second_re = second_im;
                out_second_im = -second_re;
            end
            2'd2:
            begin
                out_second_re = -second_re;
                out_second_im = -second_im;
            end
            2'd3:
            begin
                out_second_re = -second_im;
                out_second_im = second_re;
            end
            default:
            begin
                out_second_re = second_re;
                out_second_im = second_im;
            end
        endcase
    end

    // Negation keeps parity, so odd outputs mean odd inputs.
    assign valid_points = out_first_re[0] & out_first_im[0]
                        & out_second_re[0] & out_second_im[0];

    // Subset labels and the pair table.
    assign label_first  = v34te_pkg::subset_label(out_first_re[2:0], out_first_im[2:0]);
    assign label_second = v34te_pkg::subset_label(out_second_re[2:0], out_second_im[2:0]);
    assign ybits        = v34te_pkg::pair_bits(label_first, label_second);
    assign {y4, y3, y2, y1} = ybits;

    assign {d4, d3, d2, d1, d0} = state[4:0];
    assign mix_a = d0 ^ d1;
    assign mix_b = d1 ^ y1;

    // Next trellis state; unchanged when a coordinate is even.
    always_comb
    begin
        state_next = state;
        if (valid_points)
        begin
            unique case (kind)
                v34te_pkg::KIND_16:
                    state_next = {2'b00, d2 ^ y1, d1 ^ y2, d0 ^ y2, coded_bit};
                v34te_pkg::KIND_32:
                    state_next = {1'b0, d3 ^ y2, d2 ^ y4, d1 ^ y1, d0 ^ y2, coded_bit};
                v34te_pkg::KIND_64:
                    state_next = {d4 ^ d2 ^ y2, coded_bit, d2, mix_b ^ d2,
                                  mix_a ^ d3 ^ y3 ^ (y2 & d2),
                                  y4 ^ mix_a ^ (d2 & mix_b)};
                default:
                    state_next = state;
            endcase
        end
    end

endmodule

@@ sv/v34te_checker.sv @@
// ----------------------------------------------------------------------------
// V.34 4D trellis encoder port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module v34te_checker #(
    parameter int COORD_BITS = v34te_pkg::COORD_BITS_DEF,
    localparam int OUT_TW = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [OUT_TW-1:0]  m_tdata
);

    localparam int CB = COORD_BITS;

    // A stalled result keeps its valid and its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The valid flag matches the parity of the four output coordinates.
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4*CB+1] ==
                      (m_tdata[0] & m_tdata[CB] & m_tdata[2*CB] & m_tdata[3*CB])))
        else $error("valid_points disagrees with coordinate parity");

    // With the result register empty, the input side is always ready.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    // A result appearing on an empty output came from a transfer that passed straight through the input register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transfer");

    // Padding bits of the result stay zero.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_TW-1:4*CB+2] == '0))
        else $error("result padding not zero");

endmodule

bind v34_four_d_trellis_encoder_top v34te_checker #(
    .COORD_BITS (COORD_BITS)
) u_v34te_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
